// ----- hw/rtl/rat_pkg.sv -----
package rat_pkg;

	// default table depth
	localparam int SLOTS_DEF = 8;

	// field widths
	localparam int ADDR_W = 64;
	localparam int PORT_W = 16;
	localparam int ID_W   = 8;
	localparam int SLOT_W = 3;

	// request codes
	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_MARK   = 2'd2
	} req_t;

	// result codes
	typedef enum logic [2:0] {
		ST_KNOWN    = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_STORED   = 3'd2,
		ST_FULL     = 3'd3,
		ST_REMOVED  = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_MARKED   = 3'd6
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
	} dp_stat_t;

endpackage

// ----- hw/rtl/rat_ctrl.sv -----
module rat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rat_pkg::dp_stat_t   stat,
	output rat_pkg::ctl_cmd_t   cmd,
	output logic                busy
);

	rat_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		unique case (state_q)
			rat_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rat_pkg::S_SCAN;
				end
			end
			rat_pkg::S_SCAN: begin
				cmd.step = 1'b1;
				if (stat.hit || stat.last) begin
					state_d = rat_pkg::S_COMMIT;
				end
			end
			rat_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = rat_pkg::S_IDLE;
			end
			default: begin
				state_d = rat_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/rat_dp.sv -----
module rat_dp #(
	parameter int SLOTS = rat_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rat_pkg::ctl_cmd_t             cmd,
	output rat_pkg::dp_stat_t             stat,
	input  logic [1:0]                    req_type,
	input  logic [rat_pkg::ADDR_W-1:0]    addr_high,
	input  logic [rat_pkg::ADDR_W-1:0]    addr_low,
	input  logic [rat_pkg::PORT_W-1:0]    peer_port,
	input  logic [rat_pkg::ID_W-1:0]      addr_id,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [rat_pkg::SLOT_W-1:0]    slot,
	output logic                          list_received
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// table storage
	logic [rat_pkg::ADDR_W-1:0] addr_hi_mem [SLOTS];
	logic [rat_pkg::ADDR_W-1:0] addr_lo_mem [SLOTS];
	logic [rat_pkg::PORT_W-1:0] port_mem    [SLOTS];
	logic [rat_pkg::ID_W-1:0]   id_mem      [SLOTS];
	logic                       init_path_q [SLOTS];
	logic [SLOTS-1:0]           valid_q;
	logic                       received_q;

	// request registers
	logic [1:0]                 req_q;
	logic [rat_pkg::ADDR_W-1:0] hi_q;
	logic [rat_pkg::ADDR_W-1:0] lo_q;
	logic [rat_pkg::PORT_W-1:0] port_q;
	logic [rat_pkg::ID_W-1:0]   id_q;

	// scan state
	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic             known_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// result registers
	logic                       done_q;
	rat_pkg::status_t           status_q;
	logic [rat_pkg::SLOT_W-1:0] slot_q;
	logic                       list_q;

	logic cur_valid, addr_eq, id_eq, hit;

	// compare the slot under the scan pointer
	assign cur_valid = valid_q[idx_q];
	assign addr_eq   = (addr_hi_mem[idx_q] == hi_q) && (addr_lo_mem[idx_q] == lo_q);
	assign id_eq     = (id_mem[idx_q] == id_q);

	always_comb begin
		case (rat_pkg::req_t'(req_q))
			rat_pkg::REQ_ADD:    hit = cur_valid && (addr_eq || id_eq);
			rat_pkg::REQ_REMOVE: hit = cur_valid && id_eq;
			rat_pkg::REQ_MARK:   hit = cur_valid && addr_eq;
			default:             hit = 1'b0;
		endcase
	end

	assign stat.hit  = hit;
	assign stat.last = (idx_q == IDX_W'(SLOTS - 1));

	// request capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			hi_q    <= addr_high;
			lo_q    <= addr_low;
			port_q  <= peer_port;
			id_q    <= addr_id;
			idx_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.step) begin
			if (!stat.last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (hit) begin
				found_q     <= 1'b1;
				known_q     <= addr_eq;
				found_idx_q <= idx_q;
			end
			if (!cur_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
	end

	// table writes on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (rat_pkg::req_t'(req_q) == rat_pkg::REQ_ADD) begin
				if (found_q && !known_q) begin
					addr_hi_mem[found_idx_q] <= hi_q;
					addr_lo_mem[found_idx_q] <= lo_q;
					port_mem[found_idx_q]    <= port_q;
				end else if (!found_q && free_q) begin
					addr_hi_mem[free_idx_q] <= hi_q;
					addr_lo_mem[free_idx_q] <= lo_q;
					port_mem[free_idx_q]    <= port_q;
					id_mem[free_idx_q]      <= id_q;
					init_path_q[free_idx_q] <= 1'b0;
				end
			end else if (rat_pkg::req_t'(req_q) == rat_pkg::REQ_MARK && found_q) begin
				init_path_q[found_idx_q] <= 1'b1;
			end
		end
	end

	// outcome of the request
	rat_pkg::status_t       st_d;
	logic [IDX_W-1:0]       slot_d;
	logic                   recv_d;
	logic [SLOTS-1:0]       valid_d;

	always_comb begin
		st_d    = rat_pkg::ST_NOTFOUND;
		slot_d  = '0;
		recv_d  = received_q;
		valid_d = valid_q;
		case (rat_pkg::req_t'(req_q))
			rat_pkg::REQ_ADD: begin
				if (found_q) begin
					slot_d = found_idx_q;
					if (known_q) begin
						st_d = rat_pkg::ST_KNOWN;
					end else begin
						st_d   = rat_pkg::ST_UPDATED;
						recv_d = 1'b1;
					end
				end else if (free_q) begin
					st_d                = rat_pkg::ST_STORED;
					slot_d              = free_idx_q;
					recv_d              = 1'b1;
					valid_d[free_idx_q] = 1'b1;
				end else begin
					st_d = rat_pkg::ST_FULL;
				end
			end
			rat_pkg::REQ_REMOVE: begin
				if (found_q) begin
					st_d                 = rat_pkg::ST_REMOVED;
					slot_d               = found_idx_q;
					valid_d[found_idx_q] = 1'b0;
				end
			end
			rat_pkg::REQ_MARK: begin
				if (found_q) begin
					st_d   = rat_pkg::ST_MARKED;
					slot_d = found_idx_q;
				end
			end
			default: begin
				st_d = rat_pkg::ST_NOTFOUND;
			end
		endcase
	end

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			received_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				valid_q    <= valid_d;
				received_q <= recv_d;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= st_d;
			slot_q   <= rat_pkg::SLOT_W'(slot_d);
			list_q   <= recv_d;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign list_received = list_q;

endmodule

// ----- hw/rtl/remote_address_table.sv -----
// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+------------------------
// request   | req_type addr_high addr_low peer_port addr_id     | start high, busy low
// result    | status slot list_received                         | done, one cycle
//
// an item runs from accept to the edge that takes its result through the sequential
// compare scan over the slots (it stops at the first match), a commit step that
// writes the table, and the done cycle.
// busy is high from the cycle after accept until the commit; the next item can be
// accepted in the done cycle. results need no acceptance and the receiver cannot
// stall. reset clears valid bits and flags.
module remote_address_table #(
	parameter int SLOTS = rat_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [rat_pkg::ADDR_W-1:0]    addr_high,
	input  logic [rat_pkg::ADDR_W-1:0]    addr_low,
	input  logic [rat_pkg::PORT_W-1:0]    peer_port,
	input  logic [rat_pkg::ID_W-1:0]      addr_id,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [rat_pkg::SLOT_W-1:0]    slot,
	output logic                          list_received
);

	rat_pkg::ctl_cmd_t cmd;
	rat_pkg::dp_stat_t stat;

	// sequencer
	rat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table and compare datapath
	rat_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.peer_port     (peer_port),
		.addr_id       (addr_id),
		.done          (done),
		.status        (status),
		.slot          (slot),
		.list_received (list_received)
	);

endmodule
